// File: design/bse_pkg.sv
`timescale 1ns / 1ps

package bse_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: design/bse_cell.sv
`timescale 1ns / 1ps

module bse_cell (
  input  logic                                clk,
  input  bse_pkg::cell_ctrl_t                 ctrl,
  input  logic                                occ,
  input  logic signed [bse_pkg::DATA_W-1:0]   new_val,
  input  logic                                prev_gt,
  input  logic signed [bse_pkg::DATA_W-1:0]   prev_val,
  input  logic signed [bse_pkg::DATA_W-1:0]   next_val,
  output logic                                gt,
  output logic signed [bse_pkg::DATA_W-1:0]   val
);

  logic signed [bse_pkg::DATA_W-1:0] val_r;
  logic signed [bse_pkg::DATA_W-1:0] val_nxt;

  // An empty cell acts as plus infinity. Equal values keep arrival order.
  assign gt  = !occ || (new_val < val_r);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.shift) begin
      val_nxt = next_val;
    end else if (ctrl.ins && gt) begin
      // The first cell past the insertion point takes the new value;
      // the cells after it take their left neighbor's value.
      val_nxt = prev_gt ? prev_val : new_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// File: design/bubble_sort_engine_unit.sv
`timescale 1ns / 1ps

// Streaming ascending sorter for signed 32-bit values.
// Input channel: in_value with in_last_item; one beat per cycle is taken while
// the block loads a set. Each value is inserted into a chain of MAX_ITEMS
// cells in the cycle it arrives, so the chain always holds the set in order.
// The beat marked in_last_item closes the set. Values beyond MAX_ITEMS are
// dropped and every result of that set then carries out_overflow.
// Result channel: out_sorted_value, out_last_out, out_overflow. The cycle
// after the closing beat, the first result appears from cell 0; each taken
// result shifts the chain one cell toward the output. While draining, in_stall
// is high; the block reopens for input the cycle after the final result.
// No new values are taken while a set drains.
// When out_stall is high the chain holds and the result stays unchanged.
// Reset empties the chain and clears the overflow flag; no clearing pass.

module bubble_sort_engine_unit #(
  parameter int unsigned MAX_ITEMS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [bse_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [bse_pkg::DATA_W-1:0] out_sorted_value,
  output logic                              out_last_out,
  output logic                              out_overflow
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

  bse_pkg::state_t     state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  bse_pkg::cell_ctrl_t ctrl;
  logic                in_beat;
  logic                out_beat;
  logic                full;

  logic                              gt   [MAX_ITEMS];
  logic signed [bse_pkg::DATA_W-1:0] vals [MAX_ITEMS];

  assign full     = (count_r == CW'(MAX_ITEMS));
  assign in_stall = (state_r == bse_pkg::ST_DRAIN);
  assign out_valid = (state_r == bse_pkg::ST_DRAIN);
  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;

  assign out_sorted_value = vals[0];
  assign out_last_out     = (count_r == CW'(1));
  assign out_overflow     = ovf_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ovf_nxt    = ovf_r;
    ctrl.ins   = 1'b0;
    ctrl.shift = 1'b0;
    unique case (state_r)
      bse_pkg::ST_LOAD: begin
        if (in_beat) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            ctrl.ins  = 1'b1;
            count_nxt = count_r + CW'(1);
          end
          if (in_last_item) begin
            state_nxt = bse_pkg::ST_DRAIN;
          end
        end
      end
      bse_pkg::ST_DRAIN: begin
        if (out_beat) begin
          ctrl.shift = 1'b1;
          count_nxt  = count_r - CW'(1);
          if (count_r == CW'(1)) begin
            state_nxt = bse_pkg::ST_LOAD;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = bse_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bse_pkg::ST_LOAD;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                              occ;
    logic                              prev_gt;
    logic signed [bse_pkg::DATA_W-1:0] prev_val;
    logic signed [bse_pkg::DATA_W-1:0] next_val;

    assign occ = (count_r > CW'(i));

    if (i == 0) begin : g_head
      assign prev_gt  = 1'b0;
      assign prev_val = in_value;
    end else begin : g_body
      assign prev_gt  = gt[i-1];
      assign prev_val = vals[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_val = vals[i];
    end else begin : g_mid
      assign next_val = vals[i+1];
    end

    bse_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occ      (occ),
      .new_val  (in_value),
      .prev_gt  (prev_gt),
      .prev_val (prev_val),
      .next_val (next_val),
      .gt       (gt[i]),
      .val      (vals[i])
    );
  end

endmodule

// File: bench/bubble_sort_checker.sv
`timescale 1ns / 1ps

module bubble_sort_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [bse_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last_item,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [bse_pkg::DATA_W-1:0] out_sorted_value,
  input  logic                              out_last_out,
  input  logic                              out_overflow,
  output int unsigned                       mismatches,
  output int unsigned                       awaited
);

  typedef struct packed {
    logic signed [bse_pkg::DATA_W-1:0] value;
    logic                              last;
    logic                              ovf;
  } sorted_beat_t;

  logic signed [bse_pkg::DATA_W-1:0] set_store [CAPACITY];
  int                                set_count;
  logic                              set_dropped;
  sorted_beat_t                      sorted_queue [$];

  // Insertion keeps the partial set in ascending signed order at all times.
  task automatic insert_sorted(input logic signed [bse_pkg::DATA_W-1:0] v);
    int pos;
    pos = set_count;
    while (pos > 0 && v < set_store[pos-1]) begin
      set_store[pos] = set_store[pos-1];
      pos--;
    end
    set_store[pos] = v;
    set_count++;
  endtask

  always @(posedge clk) begin
    sorted_beat_t want;
    if (!rst_n) begin
      set_count = 0;
      set_dropped = 1'b0;
      sorted_queue.delete();
      mismatches = 0;
      awaited <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (set_count < CAPACITY) begin
          insert_sorted(in_value);
        end else begin
          set_dropped = 1'b1;
        end
        // A dropped closing beat still closes the set.
        if (in_last_item) begin
          for (int k = 0; k < set_count; k++) begin
            want.value = set_store[k];
            want.last = (k == set_count - 1);
            want.ovf = set_dropped;
            sorted_queue.push_back(want);
          end
          set_count = 0;
          set_dropped = 1'b0;
        end
      end

      if (out_valid && !out_stall) begin
        if (sorted_queue.size() == 0) begin
          $display("%0t: unexpected result beat, value %0d last %b overflow %b", $time,
                   out_sorted_value, out_last_out, out_overflow);
          mismatches++;
        end else begin
          want = sorted_queue.pop_front();
          if (out_sorted_value !== want.value) begin
            $display("%0t: sorted_value expected %0d, got %0d", $time, want.value,
                     out_sorted_value);
            mismatches++;
          end
          if (out_last_out !== want.last) begin
            $display("%0t: last_out expected %b, got %b", $time, want.last, out_last_out);
            mismatches++;
          end
          if (out_overflow !== want.ovf) begin
            $display("%0t: overflow expected %b, got %b", $time, want.ovf, out_overflow);
            mismatches++;
          end
        end
      end
      awaited <= sorted_queue.size();
    end
  end

endmodule

// File: bench/bubble_sort_engine_unit_tb.sv
`timescale 1ns / 1ps

module bubble_sort_engine_unit_tb;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned RANDOM_BEATS = 260;

  logic                              clk;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_stall;
  logic signed [bse_pkg::DATA_W-1:0] in_value;
  logic                              in_last_item;
  logic                              out_valid;
  logic                              out_stall;
  logic signed [bse_pkg::DATA_W-1:0] out_sorted_value;
  logic                              out_last_out;
  logic                              out_overflow;
  int unsigned                       mismatches;
  int unsigned                       awaited;
  logic                              sender_burst;

  bubble_sort_engine_unit #(
    .MAX_ITEMS(CAPACITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_value(in_value),
    .in_last_item(in_last_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sorted_value(out_sorted_value),
    .out_last_out(out_last_out),
    .out_overflow(out_overflow)
  );

  bubble_sort_checker #(
    .CAPACITY(CAPACITY)
  ) sort_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_value(in_value),
    .in_last_item(in_last_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_sorted_value(out_sorted_value),
    .out_last_out(out_last_out),
    .out_overflow(out_overflow),
    .mismatches(mismatches),
    .awaited(awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [bse_pkg::DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom();
    // Narrow range around zero gives plenty of equal values.
    if (r < 8) return $urandom_range(0, 8) - 4;
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0001;
      3: return 32'sh7fff_fffe;
      4: return 32'sh0000_0000;
      default: return -32'sd1;
    endcase
  endfunction

  // Returns at the edge where the beat is taken, with in_valid still high.
  task automatic send_beat(input logic signed [bse_pkg::DATA_W-1:0] v, input logic last);
    int unsigned gap;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last_item <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random_set(input int n);
    sender_burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      send_beat(pick_value(), i == n - 1);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off so a draining set holds and
  // the input side backs up.
  initial begin
    int unsigned cycles;
    int unsigned run_len;
    int unsigned gap;
    logic        held;
    out_stall <= 1'b0;
    cycles = 0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (run_len) @(posedge clk);
      cycles += run_len;
      if (!held && cycles >= 400) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        cycles += 150;
        held = 1'b1;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
          cycles += gap;
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned r;
    int          n;
    in_valid <= 1'b0;
    in_value <= '0;
    in_last_item <= 1'b0;
    rst_n <= 1'b0;
    sender_burst = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-value set at the top of the range.
    send_beat(32'sh7fff_ffff, 1'b1);
    // Both extremes, zero, a repeated value and small neighbors.
    send_beat(32'sh8000_0000, 1'b0);
    send_beat(32'sh7fff_ffff, 1'b0);
    send_beat(32'sh0000_0000, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sd1, 1'b1);
    // Descending set that fills the store; the last two beats are dropped,
    // the final one of them closing the set.
    for (int i = 0; i < CAPACITY + 2; i++) begin
      send_beat(9 - i, i == CAPACITY + 1);
    end

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 8) n = 1;
      else if (r < 80) n = $urandom_range(2, CAPACITY);
      else if (r < 92) n = CAPACITY;
      else n = $urandom_range(CAPACITY + 1, CAPACITY + 6);
      send_random_set(n);
      sent += n;
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (awaited != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/bse_pkg.sv
design/bse_cell.sv
design/bubble_sort_engine_unit.sv
bench/bubble_sort_checker.sv
bench/bubble_sort_engine_unit_tb.sv
